// File: src/dpfp_pkg.sv
// ============================================================================
// dpfp_pkg
// Shared types and codes of the display pixel format packer.
// ============================================================================
`default_nettype none

package dpfp_pkg;

    localparam int MAX_BURST = 4;
    localparam int CNT_W     = $clog2(MAX_BURST + 1);
    localparam int IDX_W     = $clog2(MAX_BURST);

    // pixel_format register codes
    localparam logic [2:0] FMT_ASIS    = 3'd0;
    localparam logic [2:0] FMT_SWAP16  = 3'd1;
    localparam logic [2:0] FMT_RGB444  = 3'd2;
    localparam logic [2:0] FMT_RGB332  = 3'd3;
    localparam logic [2:0] FMT_GRAY256 = 3'd4;
    localparam logic [2:0] FMT_GRAY16  = 3'd5;

    // Bytes produced by one source byte, first byte in entry 0.
    typedef struct packed {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      final_flag;
    } t_burst;

endpackage

`default_nettype wire

// File: src/display_pixel_format_packer.sv
// Latency: a source word's first output byte is valid the cycle after it is accepted.
// Throughput: one output byte per cycle while i_out_stall is low; a source word makes up
//   to 4 output bytes (4 in gray16), sent one at a time by the one-byte output port.
// A word that makes no output (first half of a 16-bit word) leaves the burst empty.
// Reset: synchronous, active low; format returns to pass through, counts and flags cleared.
// ============================================================================
// display_pixel_format_packer
// Converts a source pixel byte stream into SPI display bytes of a chosen format.
// ============================================================================
`default_nettype none

module display_pixel_format_packer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // source word channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_source_byte,
    input  wire logic       i_final_input,
    // output word channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_final_output,
    // pixel_format register write
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data
);
    import dpfp_pkg::*;

    t_burst burst;
    logic   accept;
    logic   free;

    // A new source word goes in whenever the burst register is empty or its
    // last byte leaves in this cycle, so bursts follow without a gap.
    assign o_in_stall  = !free;
    assign accept      = i_in_valid && free;
    // Register writes must come only while idle, unenforced here; always take them.
    assign o_cfg_ready = 1'b1;

    // Format register, pairing state and conversion logic.
    dpfp_convert u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_write   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_source_byte (i_source_byte),
        .i_final_input (i_final_input),
        .o_burst       (burst)
    );

    // Result register: shifts the burst out one byte per cycle while not stalled.
    dpfp_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_burst        (burst),
        .o_free         (free),
        .o_out_valid    (o_out_valid),
        .i_stall        (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_final_output (o_final_output)
    );

endmodule

`default_nettype wire

// File: src/dpfp_convert.sv
// ============================================================================
// dpfp_convert
// Format register, word pairing state and per-byte conversion to a burst.
// ============================================================================
`default_nettype none

module dpfp_convert (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_write,
    input  wire logic [2:0]    i_cfg_data,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_source_byte,
    input  wire logic          i_final_input,
    output dpfp_pkg::t_burst   o_burst
);
    import dpfp_pkg::*;

    logic [2:0] r_fmt;
    logic [7:0] r_held;
    logic       r_is_held;
    logic       r_phase;
    logic [3:0] r_blue;

    logic [7:0] n_held;
    logic       n_is_held;
    logic       n_phase;
    logic [3:0] n_blue;

    t_burst     burst;
    logic       do_pix;
    logic [15:0] pix;
    logic [3:0] pr, pg, pb;
    logic [15:0] w332, w256, wg_hi, wg_lo;

    function automatic logic [15:0] gray16_pix(input logic [3:0] nib);
        logic [5:0] g6;
        logic [4:0] g5;
        g6 = {nib, nib[3:2]};
        g5 = g6[5:1];
        return {g5, g6, g5};
    endfunction

    // r3 widened to five bits: r3 in the top, its msb repeated in the lsb
    function automatic logic [4:0] v_r5(input logic [2:0] r);
        return {r, 1'b0, r[2]};
    endfunction

    always_comb begin
        w332  = {v_r5(i_source_byte[7:5]), i_source_byte[4:2], i_source_byte[4:2],
                 i_source_byte[1:0], i_source_byte[1:0], i_source_byte[1]};
        w256  = {i_source_byte[7:3], i_source_byte[7:2], i_source_byte[7:3]};
        wg_hi = gray16_pix(i_source_byte[7:4]);
        wg_lo = gray16_pix(i_source_byte[3:0]);
    end

    always_comb begin
        burst     = '0;
        n_held    = r_held;
        n_is_held = r_is_held;
        n_phase   = r_phase;
        n_blue    = r_blue;
        do_pix    = 1'b0;
        pix       = {8'h00, i_source_byte};
        if (r_is_held) begin
            pix = {i_source_byte, r_held};
        end
        pr = pix[15:12];
        pg = pix[10:7];
        pb = pix[4:1];

        unique case (r_fmt)
            FMT_SWAP16: begin
                if (r_is_held) begin
                    burst.bytes[0] = i_source_byte;
                    burst.bytes[1] = r_held;
                    burst.count    = CNT_W'(2);
                    n_is_held      = 1'b0;
                end else if (i_final_input) begin
                    burst.bytes[0] = i_source_byte;
                    burst.count    = CNT_W'(1);
                end else begin
                    n_held    = i_source_byte;
                    n_is_held = 1'b1;
                end
            end
            FMT_RGB444: begin
                if (r_is_held || i_final_input) begin
                    do_pix    = 1'b1;
                    n_is_held = 1'b0;
                end else begin
                    n_held    = i_source_byte;
                    n_is_held = 1'b1;
                end
                if (do_pix) begin
                    if (!r_phase) begin
                        burst.bytes[0] = {pr, pg};
                        burst.bytes[1] = {pb, 4'h0};
                        burst.count    = i_final_input ? CNT_W'(2) : CNT_W'(1);
                        n_blue         = pb;
                        n_phase        = 1'b1;
                    end else begin
                        burst.bytes[0] = {r_blue, pr};
                        burst.bytes[1] = {pg, pb};
                        burst.count    = CNT_W'(2);
                        n_phase        = 1'b0;
                    end
                end
            end
            FMT_RGB332: begin
                burst.bytes[0] = w332[15:8];
                burst.bytes[1] = w332[7:0];
                burst.count    = CNT_W'(2);
            end
            FMT_GRAY256: begin
                burst.bytes[0] = w256[15:8];
                burst.bytes[1] = w256[7:0];
                burst.count    = CNT_W'(2);
            end
            FMT_GRAY16: begin
                burst.bytes[0] = wg_hi[15:8];
                burst.bytes[1] = wg_hi[7:0];
                burst.bytes[2] = wg_lo[15:8];
                burst.bytes[3] = wg_lo[7:0];
                burst.count    = CNT_W'(4);
            end
            default: begin
                // as-is and the unassigned codes
                burst.bytes[0] = i_source_byte;
                burst.count    = CNT_W'(1);
            end
        endcase

        burst.final_flag = i_final_input;
        if (i_final_input) begin
            n_is_held = 1'b0;
            n_phase   = 1'b0;
        end
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_ASIS;
            r_is_held <= 1'b0;
            r_phase   <= 1'b0;
        end else if (i_cfg_write) begin
            r_fmt     <= i_cfg_data;
            r_is_held <= 1'b0;
            r_phase   <= 1'b0;
        end else if (i_accept) begin
            r_is_held <= n_is_held;
            r_phase   <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
            r_blue <= n_blue;
        end
    end

`ifndef ASSERT_OFF
    a_held_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_held |-> (r_fmt == FMT_SWAP16 || r_fmt == FMT_RGB444))
        else $error("byte held outside a 16-bit word format");
    a_phase_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_fmt == FMT_RGB444))
        else $error("rgb444 phase set outside rgb444 format");
    a_fmt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_write |=> $stable(r_fmt))
        else $error("format changed without a register write");
`endif

endmodule

`default_nettype wire

// File: src/dpfp_emit.sv
// ============================================================================
// dpfp_emit
// Burst register that hands out one byte per cycle, unless stalled, on the output channel.
// ============================================================================
`default_nettype none

module dpfp_emit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire dpfp_pkg::t_burst i_burst,
    output logic               o_free,
    output logic               o_out_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_final_output
);
    import dpfp_pkg::*;

    logic [MAX_BURST-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_final;
    logic                      take;

    assign o_out_valid    = (r_count != '0);
    assign take           = o_out_valid && !i_stall;
    assign o_free         = (r_count == '0) || ((r_count == CNT_W'(1)) && !i_stall);
    assign o_out_byte     = r_bytes[r_idx];
    assign o_final_output = r_final && (r_count == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_count <= i_burst.count;
            r_idx   <= '0;
        end else if (take) begin
            r_count <= r_count - CNT_W'(1);
            r_idx   <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_final <= i_burst.final_flag;
        end
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BURST))
        else $error("burst count beyond its depth");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_count == '0 || (r_count == CNT_W'(1) && !i_stall)))
        else $error("burst loaded over bytes not yet sent");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_stall) |=> ($stable(r_count) && $stable(r_idx)))
        else $error("burst advanced while stalled");
`endif

endmodule

`default_nettype wire
